// File: src/intensity_to_rgb_colormap_top_macros.svh
// Assertion macros for the colormap block
`ifndef INTENSITY_TO_RGB_COLORMAP_TOP_MACROS_SVH
`define INTENSITY_TO_RGB_COLORMAP_TOP_MACROS_SVH

`ifndef SYNTH
`define ITRC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("itrc assertion failed");
`define ITRC_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("itrc forbidden condition seen");
`else
`define ITRC_ASSERT(lbl, clk, rst_n, prop)
`define ITRC_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

// File: src/itrc_pkg.sv
package itrc_pkg;

  localparam int unsigned NUM_CH = 3;
  localparam logic [7:0] FULL_SCALE = 8'd255;

  typedef enum logic [2:0] {
    PAL_GRAY    = 3'd0,
    PAL_MONO    = 3'd1,
    PAL_VIRIDIS = 3'd2,
    PAL_PLASMA  = 3'd3,
    PAL_MAGMA   = 3'd4,
    PAL_INFERNO = 3'd5,
    PAL_TURBO   = 3'd6
  } palette_e;

  typedef enum logic [1:0] {
    CFG_PALETTE_MODE = 2'd0,
    CFG_TINT_RED     = 2'd1,
    CFG_TINT_GREEN   = 2'd2,
    CFG_TINT_BLUE    = 2'd3
  } cfg_idx_e;

  // channel 0 red, 1 green, 2 blue
  typedef logic [NUM_CH-1:0][7:0] pix_t;

  typedef struct packed {
    logic [7:0]  lvl;
    logic [2:0]  mode;
    logic [10:0] scaled;
    logic [2:0]  seg;
  } s1_t;

  typedef struct packed {
    pix_t       a;
    pix_t       b;
    logic [7:0] w;
  } s2_t;

  typedef struct packed {
    logic [NUM_CH-1:0][15:0] pa;
    logic [NUM_CH-1:0][15:0] pb;
  } s3_t;

  function automatic pix_t pix(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pix_t p;
    p[0] = r;
    p[1] = g;
    p[2] = b;
    return p;
  endfunction

  // anchor colours of the colormap palettes; anything else reads black
  function automatic pix_t anchor(input logic [2:0] mode, input logic [2:0] idx);
    pix_t p;
    p = pix(8'd0, 8'd0, 8'd0);
    case (mode)
      PAL_VIRIDIS: begin
        case (idx)
          3'd0: p = pix(8'd68, 8'd1, 8'd84);
          3'd1: p = pix(8'd59, 8'd82, 8'd139);
          3'd2: p = pix(8'd33, 8'd145, 8'd140);
          3'd3: p = pix(8'd94, 8'd201, 8'd98);
          3'd4: p = pix(8'd253, 8'd231, 8'd37);
          default: p = pix(8'd0, 8'd0, 8'd0);
        endcase
      end
      PAL_PLASMA: begin
        case (idx)
          3'd0: p = pix(8'd13, 8'd8, 8'd135);
          3'd1: p = pix(8'd126, 8'd3, 8'd168);
          3'd2: p = pix(8'd204, 8'd71, 8'd120);
          3'd3: p = pix(8'd248, 8'd149, 8'd64);
          3'd4: p = pix(8'd240, 8'd249, 8'd33);
          default: p = pix(8'd0, 8'd0, 8'd0);
        endcase
      end
      PAL_MAGMA: begin
        case (idx)
          3'd0: p = pix(8'd0, 8'd0, 8'd4);
          3'd1: p = pix(8'd81, 8'd18, 8'd124);
          3'd2: p = pix(8'd183, 8'd55, 8'd121);
          3'd3: p = pix(8'd252, 8'd137, 8'd97);
          3'd4: p = pix(8'd252, 8'd253, 8'd191);
          default: p = pix(8'd0, 8'd0, 8'd0);
        endcase
      end
      PAL_INFERNO: begin
        case (idx)
          3'd0: p = pix(8'd0, 8'd0, 8'd4);
          3'd1: p = pix(8'd87, 8'd16, 8'd110);
          3'd2: p = pix(8'd188, 8'd55, 8'd84);
          3'd3: p = pix(8'd249, 8'd142, 8'd9);
          3'd4: p = pix(8'd252, 8'd255, 8'd164);
          default: p = pix(8'd0, 8'd0, 8'd0);
        endcase
      end
      PAL_TURBO: begin
        case (idx)
          3'd0: p = pix(8'd48, 8'd18, 8'd59);
          3'd1: p = pix(8'd50, 8'd101, 8'd190);
          3'd2: p = pix(8'd31, 8'd184, 8'd163);
          3'd3: p = pix(8'd164, 8'd252, 8'd60);
          3'd4: p = pix(8'd251, 8'd163, 8'd56);
          3'd5: p = pix(8'd180, 8'd4, 8'd38);
          default: p = pix(8'd0, 8'd0, 8'd0);
        endcase
      end
      default: p = pix(8'd0, 8'd0, 8'd0);
    endcase
    return p;
  endfunction

endpackage

// File: src/itrc_seg.sv
`include "intensity_to_rgb_colormap_top_macros.svh"

module itrc_seg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [7:0]        lvl_i,
  input  logic [2:0]        mode_i,
  output logic              valid_o,
  input  logic              ready_i,
  output itrc_pkg::s1_t     data_o
);

  logic          valid_q;
  itrc_pkg::s1_t data_q, data_d;
  logic [10:0]   scaled;

  // level * (anchors - 1): four segments, five for turbo
  always_comb begin
    scaled = {1'b0, lvl_i, 2'b00};
    if (mode_i == itrc_pkg::PAL_TURBO) begin
      scaled = scaled + {3'b000, lvl_i};
    end
    data_d.lvl    = lvl_i;
    data_d.mode   = mode_i;
    data_d.scaled = scaled;
    data_d.seg    = 3'(scaled >= 11'd255) + 3'(scaled >= 11'd510) + 3'(scaled >= 11'd765)
                  + 3'(scaled >= 11'd1020) + 3'(scaled >= 11'd1275);
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  `ITRC_ASSERT(a_seg_lo, clk_i, rst_ni,
    valid_q |-> ({8'd0, data_q.seg} * 11'd255 <= data_q.scaled))
  `ITRC_ASSERT(a_seg_hi, clk_i, rst_ni,
    valid_q |-> (data_q.scaled < {8'd0, data_q.seg} * 11'd255 + 11'd255))

endmodule

// File: src/itrc_sel.sv
module itrc_sel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  itrc_pkg::s1_t     data_i,
  input  logic [7:0]        tint_red_i,
  input  logic [7:0]        tint_green_i,
  input  logic [7:0]        tint_blue_i,
  output logic              valid_o,
  input  logic              ready_i,
  output itrc_pkg::s2_t     data_o
);

  logic          valid_q;
  itrc_pkg::s2_t data_q, data_d;
  logic [2:0]    last_idx;
  logic          full;
  logic [10:0]   seg_base;
  logic [10:0]   w_raw;
  logic [2:0]    idx_a, idx_b;

  // every mode reduces to (a*(255-w) + b*w) / 255 per channel
  always_comb begin
    last_idx = (data_i.mode == itrc_pkg::PAL_TURBO) ? 3'd5 : 3'd4;
    full     = data_i.seg >= last_idx;
    seg_base = {data_i.seg, 8'd0} - {8'd0, data_i.seg};
    w_raw    = data_i.scaled - seg_base;
    idx_a    = full ? last_idx : data_i.seg;
    idx_b    = full ? last_idx : data_i.seg + 3'd1;

    data_d.a = itrc_pkg::anchor(data_i.mode, idx_a);
    data_d.b = itrc_pkg::anchor(data_i.mode, idx_b);
    data_d.w = full ? 8'd0 : w_raw[7:0];

    unique case (data_i.mode)
      itrc_pkg::PAL_GRAY: begin
        data_d.a = itrc_pkg::pix(8'd0, 8'd0, 8'd0);
        data_d.b = itrc_pkg::pix(itrc_pkg::FULL_SCALE, itrc_pkg::FULL_SCALE,
                                 itrc_pkg::FULL_SCALE);
        data_d.w = data_i.lvl;
      end
      itrc_pkg::PAL_MONO: begin
        data_d.a = itrc_pkg::pix(8'd0, 8'd0, 8'd0);
        data_d.b = itrc_pkg::pix(tint_red_i, tint_green_i, tint_blue_i);
        data_d.w = data_i.lvl;
      end
      itrc_pkg::PAL_VIRIDIS, itrc_pkg::PAL_PLASMA, itrc_pkg::PAL_MAGMA,
      itrc_pkg::PAL_INFERNO, itrc_pkg::PAL_TURBO: begin
      end
      default: begin
        // unused mode gives a black pixel
        data_d.a = itrc_pkg::pix(8'd0, 8'd0, 8'd0);
        data_d.b = itrc_pkg::pix(8'd0, 8'd0, 8'd0);
        data_d.w = 8'd0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: src/itrc_mul.sv
module itrc_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  itrc_pkg::s2_t     data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output itrc_pkg::s3_t     data_o
);

  logic          valid_q;
  itrc_pkg::s3_t data_q, data_d;
  logic [7:0]    w_inv;

  always_comb begin
    w_inv = itrc_pkg::FULL_SCALE - data_i.w;
    for (int c = 0; c < itrc_pkg::NUM_CH; c++) begin
      data_d.pa[c] = {8'd0, data_i.a[c]} * {8'd0, w_inv};
      data_d.pb[c] = {8'd0, data_i.b[c]} * {8'd0, data_i.w};
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: src/itrc_norm.sv
`include "intensity_to_rgb_colormap_top_macros.svh"

module itrc_norm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  itrc_pkg::s3_t     data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output itrc_pkg::pix_t    pix_o
);

  logic                                 valid_q;
  itrc_pkg::pix_t                       pix_q, pix_d;
  logic [itrc_pkg::NUM_CH-1:0][15:0]    sum;
  logic [itrc_pkg::NUM_CH-1:0][15:0]    adj;

  // x/255 as (x + x/256 + 1)/256, exact for x up to 255*255
  always_comb begin
    for (int c = 0; c < itrc_pkg::NUM_CH; c++) begin
      sum[c]   = data_i.pa[c] + data_i.pb[c];
      adj[c]   = sum[c] + {8'd0, sum[c][15:8]} + 16'd1;
      pix_d[c] = adj[c][15:8];
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign pix_o   = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
    end
  end

  `ITRC_ASSERT(a_div_red, clk_i, rst_ni,
    valid_i |-> ({8'd0, pix_d[0]} * 16'd255 <= sum[0] &&
                 sum[0] < {8'd0, pix_d[0]} * 16'd255 + 16'd255))
  `ITRC_ASSERT(a_div_blue, clk_i, rst_ni,
    valid_i |-> ({8'd0, pix_d[2]} * 16'd255 <= sum[2] &&
                 sum[2] < {8'd0, pix_d[2]} * 16'd255 + 16'd255))

endmodule

// File: src/intensity_to_rgb_colormap_top.sv
// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_ready_o   level_i
// out       out  out_valid_o / out_ready_i out_red_o, out_green_o, out_blue_o
// cfg       in   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Four register stages: segment, anchor select, multiply, divide by 255.
// One transaction per cycle sustained while out_ready_i stays high.
// Each stage holds its own valid bit and fills bubbles while the output stalls.
// Reset clears the valid bits and loads gray mode with a white tint.

`include "intensity_to_rgb_colormap_top_macros.svh"

module intensity_to_rgb_colormap_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  logic [2:0] palette_mode_q;
  logic [7:0] tint_red_q, tint_green_q, tint_blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_mode_q <= itrc_pkg::PAL_GRAY;
      tint_red_q     <= itrc_pkg::FULL_SCALE;
      tint_green_q   <= itrc_pkg::FULL_SCALE;
      tint_blue_q    <= itrc_pkg::FULL_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        itrc_pkg::CFG_PALETTE_MODE: palette_mode_q <= cfg_wdata_i[2:0];
        itrc_pkg::CFG_TINT_RED:     tint_red_q     <= cfg_wdata_i;
        itrc_pkg::CFG_TINT_GREEN:   tint_green_q   <= cfg_wdata_i;
        itrc_pkg::CFG_TINT_BLUE:    tint_blue_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic           s1_valid, s1_ready;
  logic           s2_valid, s2_ready;
  logic           s3_valid, s3_ready;
  logic           s4_ready;
  itrc_pkg::s1_t  s1_data;
  itrc_pkg::s2_t  s2_data;
  itrc_pkg::s3_t  s3_data;
  itrc_pkg::pix_t pix;

  itrc_seg u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .lvl_i   (level_i),
    .mode_i  (palette_mode_q),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  itrc_sel u_sel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid),
    .ready_o      (s1_ready),
    .data_i       (s1_data),
    .tint_red_i   (tint_red_q),
    .tint_green_i (tint_green_q),
    .tint_blue_i  (tint_blue_q),
    .valid_o      (s2_valid),
    .ready_i      (s2_ready),
    .data_o       (s2_data)
  );

  itrc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  itrc_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .data_i  (s3_data),
    .valid_o (out_valid_o),
    .ready_i (s4_ready),
    .pix_o   (pix)
  );

  assign s4_ready    = out_ready_i;
  assign out_red_o   = pix[0];
  assign out_green_o = pix[1];
  assign out_blue_o  = pix[2];

  // back-pressure can only originate at the output
  `ITRC_ASSERT(a_stall_src, clk_i, rst_ni, !in_ready_o |-> (out_valid_o && !out_ready_i))
  `ITRC_ASSERT_NEVER(a_stall_full, clk_i, rst_ni,
    !in_ready_o && !(s1_valid && s2_valid && s3_valid))

endmodule
